### src/cda_pkg.sv
// ----------------------------------------------------------------------------
// cda_pkg
// Types, constants and calendar helper functions for the calendar date unit.
// ----------------------------------------------------------------------------
`default_nettype none

package cda_pkg;

   localparam int DAY_W   = 5;
   localparam int MONTH_W = 4;
   localparam int YEAR_W  = 14;
   localparam int OFF_W   = 23;
   localparam int DIST_W  = 22;
   localparam int REL_W   = 23;   // stored day count relative to the epoch
   localparam int ACC_W   = 24;   // working accumulator, holds count plus offset
   localparam int YLEN_W  = 9;

   localparam logic [YEAR_W-1:0]  EPOCH_YEAR  = 14'd2000;
   localparam logic [YEAR_W-1:0]  YEAR_MIN    = 14'd1;
   localparam logic [YEAR_W-1:0]  YEAR_MAX    = 14'd9999;
   localparam logic [MONTH_W-1:0] MONTH_FIRST = 4'd1;
   localparam logic [MONTH_W-1:0] FEBRUARY    = 4'd2;
   localparam logic [MONTH_W-1:0] MONTH_LAST  = 4'd12;
   localparam logic [DAY_W-1:0]   DAY_FIRST   = 5'd1;

   // Day counts of 1 January 0001 and 31 December 9999 relative to the epoch.
   localparam logic signed [ACC_W-1:0] REL_MIN = -24'sd730119;
   localparam logic signed [ACC_W-1:0] REL_MAX = 24'sd2921939;

   localparam logic [YLEN_W-1:0] DAYS_YEAR    = 9'd365;
   localparam logic [6:0]        CENTURY_LAST = 7'd99;
   localparam logic [8:0]        ERA_LAST     = 9'd399;

   localparam logic [DAY_W-1:0] MONTH_LEN [0:11] = '{
      5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
      5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
   };

   typedef enum logic [1:0] {
      OP_SET  = 2'd0,
      OP_ADD  = 2'd1,
      OP_DIFF = 2'd2,
      OP_NOP  = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_YEAR_TO,
      ST_MONTH_TO,
      ST_YEAR_FROM,
      ST_MONTH_FROM,
      ST_REPLY
   } state_type;

   typedef enum logic [2:0] {
      DP_IDLE,
      DP_LOAD,
      DP_CHECK,
      DP_YEAR_TO,
      DP_MONTH_TO,
      DP_YEAR_FROM,
      DP_MONTH_FROM,
      DP_REPLY
   } dp_cmd_type;

   typedef struct packed {
      op_type op;
      logic   pre_ok;     // captured date passes the checks that need no leap flag
      logic   range_ok;   // sum of day count and offset lies inside the calendar
      logic   year_hit;   // year walk reached the target year
      logic   month_hit;  // month walk reached the target month
      logic   year_fit;   // remaining days fall inside the current year
      logic   month_fit;  // remaining days fall inside the current month
   } dp_status_type;

   // Leap rule from the year's residues modulo 4, 100 and 400.
   function automatic logic is_leap(input logic [1:0] r4, input logic [6:0] r100,
                                    input logic [8:0] r400);
      return (r400 == 9'd0) || ((r100 != 7'd0) && (r4 == 2'd0));
   endfunction

   function automatic logic [YLEN_W-1:0] year_len(input logic leap);
      return DAYS_YEAR + {{(YLEN_W-1){1'b0}}, leap};
   endfunction

   // Length of a month; zero for a code that is no month.
   function automatic logic [DAY_W-1:0] days_in_month(input logic [MONTH_W-1:0] m,
                                                      input logic leap);
      logic [MONTH_W-1:0] idx;
      logic [DAY_W-1:0]   len;
      idx = m - MONTH_FIRST;
      if (m < MONTH_FIRST || m > MONTH_LAST) begin
         len = '0;
      end else begin
         len = MONTH_LEN[idx] + {{(DAY_W-1){1'b0}}, (m == FEBRUARY) && leap};
      end
      return len;
   endfunction

endpackage

`default_nettype wire

### src/cda_controller.sv
// ----------------------------------------------------------------------------
// cda_controller
// Sequencer for the calendar date unit: accepts a word, steps the datapath
// through the year and month walks and triggers the reply.
// ----------------------------------------------------------------------------
`default_nettype none

module cda_controller
   import cda_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   output logic               busy,
   input  wire dp_status_type status,
   output dp_cmd_type         cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_CHECK;
         end
         ST_CHECK: begin
            case (status.op)
               OP_SET, OP_DIFF: state_in = status.pre_ok ? ST_YEAR_TO : ST_REPLY;
               OP_ADD:          state_in = status.range_ok ? ST_YEAR_FROM : ST_REPLY;
               default:         state_in = ST_REPLY;
            endcase
         end
         ST_YEAR_TO: begin
            if (status.year_hit) state_in = ST_MONTH_TO;
         end
         ST_MONTH_TO: begin
            if (status.month_hit) state_in = ST_REPLY;
         end
         ST_YEAR_FROM: begin
            if (status.year_fit) state_in = ST_MONTH_FROM;
         end
         ST_MONTH_FROM: begin
            if (status.month_fit) state_in = ST_REPLY;
         end
         ST_REPLY: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs.
   always_comb begin
      busy = 1'b1;
      cmd  = DP_IDLE;
      case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            cmd  = start ? DP_LOAD : DP_IDLE;
         end
         ST_CHECK:      cmd = DP_CHECK;
         ST_YEAR_TO:    cmd = status.year_hit ? DP_IDLE : DP_YEAR_TO;
         ST_MONTH_TO:   cmd = status.month_hit ? DP_IDLE : DP_MONTH_TO;
         ST_YEAR_FROM:  cmd = status.year_fit ? DP_IDLE : DP_YEAR_FROM;
         ST_MONTH_FROM: cmd = status.month_fit ? DP_IDLE : DP_MONTH_FROM;
         ST_REPLY:      cmd = DP_REPLY;
         default:       cmd = DP_IDLE;
      endcase
   end

endmodule

`default_nettype wire

### src/cda_datapath.sv
// ----------------------------------------------------------------------------
// cda_datapath
// Stored date, day-count accumulator, year and month walkers with running
// leap residues, and the result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module cda_datapath
   import cda_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire dp_cmd_type           cmd,
   output dp_status_type             status,
   input  wire logic [1:0]           req_op,
   input  wire logic [DAY_W-1:0]     req_in_day,
   input  wire logic [MONTH_W-1:0]   req_in_month,
   input  wire logic [YEAR_W-1:0]    req_in_year,
   input  wire logic signed [OFF_W-1:0] req_offset_days,
   output logic                      rsp_strobe,
   output logic [DAY_W-1:0]          rsp_out_day,
   output logic [MONTH_W-1:0]        rsp_out_month,
   output logic [YEAR_W-1:0]         rsp_out_year,
   output logic                      rsp_leap,
   output logic [DIST_W-1:0]         rsp_distance,
   output logic                      rsp_error
);

   // Stored date and its day count relative to the epoch.
   logic [DAY_W-1:0]          cur_day_ff,   cur_day_in;
   logic [MONTH_W-1:0]        cur_month_ff, cur_month_in;
   logic [YEAR_W-1:0]         cur_year_ff,  cur_year_in;
   logic                      cur_leap_ff,  cur_leap_in;
   logic signed [REL_W-1:0]   cur_rel_ff,   cur_rel_in;

   // Year walker with residues of the walking year modulo 4, 100 and 400.
   logic [YEAR_W-1:0]         yc_ff,   yc_in;
   logic [1:0]                r4_ff,   r4_in;
   logic [6:0]                r100_ff, r100_in;
   logic [8:0]                r400_ff, r400_in;

   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   logic signed [ACC_W-1:0]   sum_ff, sum_in;
   logic [MONTH_W-1:0]        mc_ff,  mc_in;

   op_type                    op_ff, op_in;
   logic [DAY_W-1:0]          tgt_day_ff,   tgt_day_in;
   logic [MONTH_W-1:0]        tgt_month_ff, tgt_month_in;
   logic [YEAR_W-1:0]         tgt_year_ff,  tgt_year_in;
   logic                      err_ff, err_in;

   logic                      rsp_strobe_ff, rsp_strobe_in;
   logic                      rsp_error_ff,  rsp_error_in;
   logic [DIST_W-1:0]         rsp_distance_ff, rsp_distance_in;

   // Combinational helpers.
   logic [1:0]                r4_inc, r4_dec;
   logic [6:0]                r100_inc, r100_dec;
   logic [8:0]                r400_inc, r400_dec;
   logic                      leap_now, leap_prev;
   logic signed [ACC_W-1:0]   len_now_ext, len_prev_ext, dim_ext;
   logic [DAY_W-1:0]          dim_mc, dim_tgt;
   logic signed [ACC_W-1:0]   day_ext, cur_ext, diff_ab, diff_ba;
   logic                      to_up, from_up, setdiff, err_now;

   assign r4_inc   = r4_ff + 2'd1;
   assign r4_dec   = r4_ff - 2'd1;
   assign r100_inc = (r100_ff == CENTURY_LAST) ? 7'd0 : r100_ff + 7'd1;
   assign r100_dec = (r100_ff == 7'd0) ? CENTURY_LAST : r100_ff - 7'd1;
   assign r400_inc = (r400_ff == ERA_LAST) ? 9'd0 : r400_ff + 9'd1;
   assign r400_dec = (r400_ff == 9'd0) ? ERA_LAST : r400_ff - 9'd1;

   assign leap_now  = is_leap(r4_ff, r100_ff, r400_ff);
   assign leap_prev = is_leap(r4_dec, r100_dec, r400_dec);

   assign len_now_ext  = signed'({{(ACC_W-YLEN_W){1'b0}}, year_len(leap_now)});
   assign len_prev_ext = signed'({{(ACC_W-YLEN_W){1'b0}}, year_len(leap_prev)});
   assign dim_mc       = days_in_month(mc_ff, leap_now);
   assign dim_ext      = signed'({{(ACC_W-DAY_W){1'b0}}, dim_mc});
   assign dim_tgt      = days_in_month(tgt_month_ff, leap_now);

   assign day_ext = signed'({{(ACC_W-DAY_W){1'b0}}, req_in_day});
   assign cur_ext = ACC_W'(cur_rel_ff);
   assign diff_ab = cur_ext - acc_ff;
   assign diff_ba = acc_ff - cur_ext;

   assign to_up   = tgt_year_ff > yc_ff;
   assign from_up = !acc_ff[ACC_W-1];
   assign setdiff = (op_ff == OP_SET) || (op_ff == OP_DIFF);
   // The day bound depends on the leap flag, known only once the walk has ended.
   assign err_now = err_ff || (setdiff && (tgt_day_ff > dim_tgt));

   always_comb begin
      status.op        = op_ff;
      status.pre_ok    = (tgt_year_ff inside {[YEAR_MIN:YEAR_MAX]})
                         && (tgt_month_ff inside {[MONTH_FIRST:MONTH_LAST]})
                         && (tgt_day_ff >= DAY_FIRST);
      status.range_ok  = (acc_ff >= REL_MIN) && (acc_ff <= REL_MAX);
      status.year_hit  = (yc_ff == tgt_year_ff);
      status.month_hit = (mc_ff == tgt_month_ff);
      status.year_fit  = from_up && (acc_ff < len_now_ext);
      status.month_fit = (mc_ff == MONTH_LAST) || (acc_ff < dim_ext);
   end

   always_comb begin
      cur_day_in      = cur_day_ff;
      cur_month_in    = cur_month_ff;
      cur_year_in     = cur_year_ff;
      cur_leap_in     = cur_leap_ff;
      cur_rel_in      = cur_rel_ff;
      yc_in           = yc_ff;
      r4_in           = r4_ff;
      r100_in         = r100_ff;
      r400_in         = r400_ff;
      acc_in          = acc_ff;
      sum_in          = sum_ff;
      mc_in           = mc_ff;
      op_in           = op_ff;
      tgt_day_in      = tgt_day_ff;
      tgt_month_in    = tgt_month_ff;
      tgt_year_in     = tgt_year_ff;
      err_in          = err_ff;
      rsp_strobe_in   = 1'b0;
      rsp_error_in    = rsp_error_ff;
      rsp_distance_in = rsp_distance_ff;
      case (cmd)
         DP_LOAD: begin
            op_in        = op_type'(req_op);
            tgt_day_in   = req_in_day;
            tgt_month_in = req_in_month;
            tgt_year_in  = req_in_year;
            yc_in        = EPOCH_YEAR;
            r4_in        = '0;
            r100_in      = '0;
            r400_in      = '0;
            mc_in        = MONTH_FIRST;
            sum_in       = cur_ext + ACC_W'(req_offset_days);
            if (op_type'(req_op) == OP_ADD) begin
               acc_in = sum_in;
            end else begin
               acc_in = day_ext - ACC_W'(1);
            end
         end
         DP_CHECK: begin
            case (op_ff)
               OP_ADD:          err_in = !status.range_ok;
               OP_SET, OP_DIFF: err_in = !status.pre_ok;
               default:         err_in = 1'b0;
            endcase
         end
         DP_YEAR_TO, DP_YEAR_FROM: begin
            if ((cmd == DP_YEAR_TO) ? to_up : from_up) begin
               yc_in   = yc_ff + YEAR_W'(1);
               r4_in   = r4_inc;
               r100_in = r100_inc;
               r400_in = r400_inc;
               acc_in  = (cmd == DP_YEAR_TO) ? acc_ff + len_now_ext : acc_ff - len_now_ext;
            end else begin
               yc_in   = yc_ff - YEAR_W'(1);
               r4_in   = r4_dec;
               r100_in = r100_dec;
               r400_in = r400_dec;
               acc_in  = (cmd == DP_YEAR_TO) ? acc_ff - len_prev_ext : acc_ff + len_prev_ext;
            end
         end
         DP_MONTH_TO: begin
            acc_in = acc_ff + dim_ext;
            mc_in  = mc_ff + MONTH_W'(1);
         end
         DP_MONTH_FROM: begin
            acc_in = acc_ff - dim_ext;
            mc_in  = mc_ff + MONTH_W'(1);
         end
         DP_REPLY: begin
            rsp_strobe_in   = 1'b1;
            rsp_error_in    = err_now;
            rsp_distance_in = '0;
            if (!err_now) begin
               case (op_ff)
                  OP_SET: begin
                     cur_day_in   = tgt_day_ff;
                     cur_month_in = tgt_month_ff;
                     cur_year_in  = tgt_year_ff;
                     cur_leap_in  = leap_now;
                     cur_rel_in   = signed'(acc_ff[REL_W-1:0]);
                  end
                  OP_ADD: begin
                     cur_day_in   = acc_ff[DAY_W-1:0] + DAY_W'(1);
                     cur_month_in = mc_ff;
                     cur_year_in  = yc_ff;
                     cur_leap_in  = leap_now;
                     cur_rel_in   = signed'(sum_ff[REL_W-1:0]);
                  end
                  OP_DIFF: begin
                     rsp_distance_in = (cur_ext >= acc_ff) ? diff_ab[DIST_W-1:0]
                                                           : diff_ba[DIST_W-1:0];
                  end
                  default: begin
                     rsp_distance_in = '0;
                  end
               endcase
            end
         end
         default: begin
            rsp_strobe_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_day_ff    <= DAY_FIRST;
         cur_month_ff  <= MONTH_FIRST;
         cur_year_ff   <= EPOCH_YEAR;
         cur_leap_ff   <= 1'b1;
         cur_rel_ff    <= '0;
         yc_ff         <= EPOCH_YEAR;
         r4_ff         <= '0;
         r100_ff       <= '0;
         r400_ff       <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         cur_day_ff    <= cur_day_in;
         cur_month_ff  <= cur_month_in;
         cur_year_ff   <= cur_year_in;
         cur_leap_ff   <= cur_leap_in;
         cur_rel_ff    <= cur_rel_in;
         yc_ff         <= yc_in;
         r4_ff         <= r4_in;
         r100_ff       <= r100_in;
         r400_ff       <= r400_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff          <= acc_in;
      sum_ff          <= sum_in;
      mc_ff           <= mc_in;
      op_ff           <= op_in;
      tgt_day_ff      <= tgt_day_in;
      tgt_month_ff    <= tgt_month_in;
      tgt_year_ff     <= tgt_year_in;
      err_ff          <= err_in;
      rsp_error_ff    <= rsp_error_in;
      rsp_distance_ff <= rsp_distance_in;
   end

   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_out_day   = cur_day_ff;
   assign rsp_out_month = cur_month_ff;
   assign rsp_out_year  = cur_year_ff;
   assign rsp_leap      = cur_leap_ff;
   assign rsp_distance  = rsp_distance_ff;
   assign rsp_error     = rsp_error_ff;

   // The walker starts on a multiple of four, so its mod-4 residue tracks the year.
   a_residue_tracks_year: assert property (@(posedge clock) disable iff (reset)
      r4_ff == yc_ff[1:0])
      else $error("year residue out of step with walking year");

   a_leap_needs_mult4: assert property (@(posedge clock) disable iff (reset)
      cur_leap_ff |-> (cur_year_ff[1:0] == 2'b00))
      else $error("leap flag set for a year not divisible by four");

   a_strobe_after_reply: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> $past(cmd == DP_REPLY))
      else $error("result strobe without a reply command");

   a_error_no_distance: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && rsp_error_ff) |-> (rsp_distance_ff == '0))
      else $error("distance reported with an error");

   a_month_walk_bound: assert property (@(posedge clock) disable iff (reset)
      (cmd == DP_MONTH_FROM) |-> (mc_ff < MONTH_LAST))
      else $error("month walk stepped past December");

endmodule

`default_nettype wire

### src/calendar_date_arithmetic.sv
// ----------------------------------------------------------------------------
// calendar_date_arithmetic
// From accept to strobe: no-op words, out-of-range adds and set/diff words
// whose year or month is out of range or whose day is zero go from the check
// straight to the reply; other set/diff words walk the years from 2000 to the
// target year and then the months, add walks the years from 2000 and then
// the months. One word at a time: start is taken again in the strobe cycle.
// Year walk: one year a cycle. Synchronous reset restores 1 January 2000.
// ----------------------------------------------------------------------------
`default_nettype none

module calendar_date_arithmetic
   import cda_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   output logic                         busy,
   input  wire logic [1:0]              req_op,
   input  wire logic [DAY_W-1:0]        req_in_day,
   input  wire logic [MONTH_W-1:0]      req_in_month,
   input  wire logic [YEAR_W-1:0]       req_in_year,
   input  wire logic signed [OFF_W-1:0] req_offset_days,
   output logic                         rsp_strobe,
   output logic [DAY_W-1:0]             rsp_out_day,
   output logic [MONTH_W-1:0]           rsp_out_month,
   output logic [YEAR_W-1:0]            rsp_out_year,
   output logic                         rsp_leap,
   output logic [DIST_W-1:0]            rsp_distance,
   output logic                         rsp_error
);

   dp_cmd_type    cmd;
   dp_status_type status;

   cda_controller u_controller (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   cda_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_op          (req_op),
      .req_in_day      (req_in_day),
      .req_in_month    (req_in_month),
      .req_in_year     (req_in_year),
      .req_offset_days (req_offset_days),
      .rsp_strobe      (rsp_strobe),
      .rsp_out_day     (rsp_out_day),
      .rsp_out_month   (rsp_out_month),
      .rsp_out_year    (rsp_out_year),
      .rsp_leap        (rsp_leap),
      .rsp_distance    (rsp_distance),
      .rsp_error       (rsp_error)
   );

endmodule

`default_nettype wire
